// ===== hw/rtl/step_rate_motion_controller_core_defines.svh =====
// Assertion macros for the checker file of the step-rate controller.
// No dependencies; include this file by its bare name.
`ifndef STEP_RATE_MOTION_CONTROLLER_CORE_DEFINES_SVH
`define STEP_RATE_MOTION_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srmc assertion failed");

// Next-cycle implication, disabled during reset.
`define SRMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srmc assertion failed");

// Next-cycle implication that also holds across reset.
`define SRMC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srmc assertion failed");

`endif

// ===== hw/rtl/srmc_pkg.sv =====
// Shared constants and saturating arithmetic helpers for the step-rate controller.
// No dependencies.
package srmc_pkg;

  localparam int TICK_FREQUENCY     = 1000000;
  localparam int RATE_FRACTION_BITS = 32;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  localparam logic signed [63:0] NS_PER_S = 64'sd1000000000;
  localparam logic signed [63:0] Q_ONE    = 64'sh0000_0001_0000_0000;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return S64_MAX;
    if (a[63] && b[63] && !s[63]) return S64_MIN;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (!a[63] && b[63] && s[63]) return S64_MAX;
    if (a[63] && !b[63] && !s[63]) return S64_MIN;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

endpackage

// ===== hw/rtl/srmc_cmd_if.sv =====
// Request channel of the step-rate controller: handshake and one servo request.
// No dependencies.
interface srmc_cmd_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] feedback_count;
  logic signed [63:0] position_command;
  logic signed [63:0] velocity_command;
  logic               velocity_mode;
  logic               enable;
  logic               position_clear;

  modport source(output valid, op, feedback_count, position_command, velocity_command,
                 velocity_mode, enable, position_clear, input ready);
  modport sink(input valid, op, feedback_count, position_command, velocity_command,
               velocity_mode, enable, position_clear, output ready);
endinterface

// ===== hw/rtl/srmc_rsp_if.sv =====
// Result channel of the step-rate controller: handshake and one servo result.
// No dependencies.
interface srmc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] position_feedback;
  logic signed [63:0] velocity_feedback;
  logic               direction;
  logic [31:0]        step_rate;

  modport source(output valid, position_feedback, velocity_feedback, direction,
                 step_rate, input ready);
  modport sink(input valid, position_feedback, velocity_feedback, direction,
               step_rate, output ready);
endinterface

// ===== hw/rtl/srmc_muldiv.sv =====
// Shared multiply-divide unit: round(x * m / d), ties away from zero, saturated.
// Depends on srmc_pkg. Four 32x32 partial products, then one quotient bit per cycle.
module srmc_muldiv (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] x,
  input  logic signed [63:0] m,
  input  logic [63:0]        d,
  output logic               done,
  output logic signed [63:0] result
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_CHK  = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_RND  = 3'd4;
  localparam logic [2:0] PH_INC  = 3'd5;
  localparam logic [2:0] PH_OUT  = 3'd6;

  logic [2:0]   phase;
  logic [63:0]  a;
  logic [63:0]  b;
  logic         neg;
  logic [63:0]  dr;
  logic [127:0] prod;
  logic [1:0]   k;
  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [63:0]  q;
  logic [5:0]   cnt;
  logic         up;

  logic [63:0]  lim;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  rem_sh;
  logic         carry;
  logic [63:0]  q_lim;

  assign lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

  always_comb begin
    pp    = 64'(a[32*k[1] +: 32]) * 64'(b[32*k[0] +: 32]);
    case (k)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    carry  = rem[63];
    rem_sh = {rem[62:0], lo[63]};
    q_lim  = (q > lim) ? lim : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            a     <= srmc_pkg::magnitude(x);
            b     <= srmc_pkg::magnitude(m);
            neg   <= x[63] != m[63];
            dr    <= d;
            prod  <= '0;
            k     <= 2'd0;
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          prod <= prod + pp_sh;
          k    <= k + 2'd1;
          if (k == 2'd3) phase <= PH_CHK;
        end
        PH_CHK: begin
          if (prod == '0) begin
            q     <= '0;
            phase <= PH_OUT;
          end else if (dr == '0 || prod[127:64] >= dr) begin
            q     <= lim;
            phase <= PH_OUT;
          end else begin
            rem   <= prod[127:64];
            lo    <= prod[63:0];
            q     <= '0;
            cnt   <= '0;
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          if (carry || rem_sh >= dr) begin
            rem <= rem_sh - dr;
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[62:0], 1'b0};
          end
          lo  <= {lo[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) phase <= PH_RND;
        end
        PH_RND: begin
          up    <= rem >= (dr - rem);
          phase <= PH_INC;
        end
        PH_INC: begin
          if (up) q <= (q == '1) ? lim : q + 64'd1;
          phase <= PH_OUT;
        end
        PH_OUT: begin
          result <= neg ? -$signed(q_lim) : $signed(q_lim);
          done   <= 1'b1;
          phase  <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/step_rate_motion_controller_core.sv =====
// Step-rate motion controller: top level with sequencer, state and configuration.
// Depends on srmc_pkg, srmc_cmd_if, srmc_rsp_if and srmc_muldiv.
//
// One request per servo period. A latch request (op 0) goes to the final state,
// which loads its result into the output register once that is free. A full
// update (op 1) runs three to eleven passes through one shared multiply-divide
// unit (four partial products, then a 64-step divider making one quotient bit
// per cycle; a zero or saturating product skips the divider). The block takes
// no request while an update runs, but accepts the next one while a finished
// result still waits in the output register. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the
// block is idle, and the block itself leaves this unchecked.
module step_rate_motion_controller_core (
  input  logic        clk,
  input  logic        rst,
  srmc_cmd_if.sink    cmd,
  srmc_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_MAXVEL = 2'd1;
  localparam logic [1:0] REG_MAXACC = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [3:0] OP_DPOS = 4'd0;
  localparam logic [3:0] OP_T    = 4'd1;
  localparam logic [3:0] OP_PHYS = 4'd2;
  localparam logic [3:0] OP_FF   = 4'd3;
  localparam logic [3:0] OP_VERR = 4'd4;
  localparam logic [3:0] OP_PAM  = 4'd5;
  localparam logic [3:0] OP_PCAM = 4'd6;
  localparam logic [3:0] OP_Y    = 4'd7;
  localparam logic [3:0] OP_DA   = 4'd8;
  localparam logic [3:0] OP_MP   = 4'd9;
  localparam logic [3:0] OP_TERM = 4'd10;
  localparam logic [3:0] OP_MP2  = 4'd11;
  localparam logic [3:0] OP_DV   = 4'd12;
  localparam logic [3:0] OP_RATE = 4'd13;

  localparam logic signed [63:0] PHYS_MUL     = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] TICK_S64     = 64'(srmc_pkg::TICK_FREQUENCY);
  localparam logic [63:0]        RATE_DIVISOR =
    64'(srmc_pkg::TICK_FREQUENCY) << (48 - srmc_pkg::RATE_FRACTION_BITS);

  // Configuration registers.
  logic signed [31:0] scale;
  logic [62:0]        max_vel;
  logic [62:0]        max_acc;
  logic [26:0]        period;

  // Persistent state.
  logic signed [63:0] last_pc;
  logic [31:0]        last_fb;
  logic signed [63:0] acc;
  logic signed [63:0] cv;

  // Latched request.
  logic signed [63:0] pc_r;
  logic signed [63:0] vc_r;
  logic               vm_r;
  logic               en_r;
  logic signed [31:0] dd_r;

  // Working registers.
  logic [2:0]         state;
  logic [3:0]         step;
  logic signed [63:0] tt;
  logic signed [63:0] maxv;
  logic signed [63:0] ff;
  logic signed [63:0] verr;
  logic signed [63:0] t;
  logic signed [63:0] ma;
  logic signed [63:0] pam;
  logic signed [63:0] err;
  logic signed [63:0] mp;
  logic signed [63:0] nv;
  logic signed [63:0] dv;
  logic               dir;

  logic signed [63:0] res_pos;
  logic signed [63:0] res_vel;
  logic               res_dir;
  logic [31:0]        res_sp;

  // Unit connections.
  logic               md_start;
  logic signed [63:0] md_x;
  logic signed [63:0] md_m;
  logic [63:0]        md_d;
  logic               md_done;
  logic signed [63:0] md_r;

  logic [26:0]        p_eff;
  logic [31:0]        smag;
  logic signed [63:0] acc_a;
  logic signed [63:0] verr_c;
  logic signed [63:0] lo_c;
  logic signed [63:0] hi_c;
  logic signed [63:0] nc;
  logic [63:0]        rmag;

  assign p_eff    = (period == '0) ? 27'd1 : period;
  assign smag     = scale[31] ? 32'(-scale) : 32'(scale);
  assign acc_a    = $signed({1'b0, max_acc});
  assign cmd.ready = (state == ST_IDLE);
  assign md_start = (state == ST_ISSUE);

  always_comb begin
    md_x = '0;
    md_m = '0;
    md_d = '0;
    case (step)
      OP_DPOS: begin
        md_x = 64'(dd_r);
        md_m = srmc_pkg::Q_ONE;
        md_d = {32'd0, smag};
      end
      OP_T: begin
        md_x = $signed({37'd0, p_eff});
        md_m = srmc_pkg::Q_ONE;
        md_d = 64'(srmc_pkg::NS_PER_S);
      end
      OP_PHYS: begin
        md_x = TICK_S64;
        md_m = PHYS_MUL;
        md_d = {32'd0, smag};
      end
      OP_FF: begin
        md_x = srmc_pkg::sat_sub(pc_r, last_pc);
        md_m = srmc_pkg::NS_PER_S;
        md_d = {37'd0, p_eff};
      end
      OP_VERR: begin
        md_x = verr;
        md_m = (max_acc == '0) ? srmc_pkg::NS_PER_S : srmc_pkg::Q_ONE;
        md_d = (max_acc == '0) ? {37'd0, p_eff} : {1'b0, max_acc};
      end
      OP_PAM: begin
        md_x = srmc_pkg::sat_add(ff, cv);
        md_m = srmc_pkg::sat_add(t, tt);
        md_d = 64'h0000_0002_0000_0000;
      end
      OP_PCAM: begin
        md_x = ff;
        md_m = t;
        md_d = 64'(srmc_pkg::Q_ONE);
      end
      OP_Y: begin
        md_x = err;
        md_m = srmc_pkg::NS_PER_S;
        md_d = {36'd0, p_eff, 1'b0};
      end
      OP_DA: begin
        md_x = acc_a;
        md_m = $signed({37'd0, p_eff});
        md_d = 64'(srmc_pkg::NS_PER_S);
      end
      OP_MP, OP_MP2: begin
        md_x = ma;
        md_m = tt;
        md_d = 64'(srmc_pkg::Q_ONE);
      end
      OP_TERM: begin
        md_x = mp;
        md_m = t;
        md_d = 64'h0000_0000_4000_0000;
      end
      OP_DV: begin
        md_x = srmc_pkg::sat_sub(nv, cv);
        md_m = srmc_pkg::NS_PER_S;
        md_d = {37'd0, p_eff};
      end
      OP_RATE: begin
        md_x = nv;
        md_m = 64'(scale);
        md_d = RATE_DIVISOR;
      end
      default: begin
        md_x = '0;
      end
    endcase
  end

  always_comb begin
    verr_c = srmc_pkg::sat_sub(cv, md_r);
    lo_c   = srmc_pkg::sat_sub(cv, md_r);
    hi_c   = srmc_pkg::sat_add(cv, md_r);
    rmag   = srmc_pkg::magnitude(md_r);
    if (nv < -maxv)     nc = -maxv;
    else if (nv > maxv) nc = maxv;
    else                nc = nv;
  end

  srmc_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .x      (md_x),
    .m      (md_m),
    .d      (md_d),
    .done   (md_done),
    .result (md_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= 32'sd65536;
      max_vel   <= '0;
      max_acc   <= 63'h0000_0001_0000_0000;
      period    <= 27'd1000000;
      last_pc   <= '0;
      last_fb   <= '0;
      acc       <= '0;
      cv        <= '0;
      state     <= ST_IDLE;
      step      <= OP_DPOS;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCALE:  scale   <= $signed(cfg_data[31:0]);
          REG_MAXVEL: max_vel <= cfg_data;
          REG_MAXACC: max_acc <= cfg_data;
          REG_PERIOD: period  <= cfg_data[26:0];
          default:    period  <= period;
        endcase
      end

      // The final state reloads the output register itself.
      if (rsp.valid && rsp.ready && state != ST_FIN) rsp.valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            last_fb <= cmd.feedback_count;
            pc_r    <= cmd.position_command;
            vc_r    <= cmd.velocity_command;
            vm_r    <= cmd.velocity_mode;
            en_r    <= cmd.enable;
            dd_r    <= $signed(cmd.feedback_count - last_fb);
            if (!cmd.op) begin
              res_pos <= acc;
              res_vel <= cv;
              res_dir <= 1'b0;
              res_sp  <= '0;
              state   <= ST_FIN;
            end else begin
              if (cmd.position_clear) begin
                acc  <= '0;
                step <= OP_T;
              end else begin
                step <= (scale != '0) ? OP_DPOS : OP_T;
              end
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (md_done) begin
            state <= ST_ISSUE;
            case (step)
              OP_DPOS: begin
                acc  <= srmc_pkg::sat_add(acc, scale[31] ? srmc_pkg::sat_neg(md_r) : md_r);
                step <= OP_T;
              end
              OP_T: begin
                tt   <= md_r;
                step <= OP_PHYS;
              end
              OP_PHYS: begin
                maxv <= (max_vel == '0 || {1'b0, max_vel} > md_r) ? md_r
                                                                 : $signed({1'b0, max_vel});
                if (!vm_r) begin
                  step <= OP_FF;
                end else begin
                  nv <= vc_r;
                  if (max_acc != '0) step <= OP_DV;
                  else state <= ST_CLAMP;
                end
              end
              OP_FF: begin
                ff      <= md_r;
                last_pc <= pc_r;
                verr    <= verr_c;
                if (verr_c == '0) begin
                  ma   <= '0;
                  t    <= '0;
                  step <= OP_PAM;
                end else begin
                  if (max_acc != '0) ma <= verr_c[63] ? acc_a : -acc_a;
                  step <= OP_VERR;
                end
              end
              OP_VERR: begin
                if (max_acc == '0) begin
                  ma <= srmc_pkg::sat_neg(md_r);
                  t  <= tt;
                end else begin
                  t <= md_r[63] ? srmc_pkg::sat_neg(md_r) : md_r;
                end
                step <= OP_PAM;
              end
              OP_PAM: begin
                pam  <= srmc_pkg::sat_add(acc, md_r);
                step <= OP_PCAM;
              end
              OP_PCAM: begin
                err  <= srmc_pkg::sat_sub(pam, srmc_pkg::sat_add(pc_r, md_r));
                step <= (t < tt) ? OP_Y : OP_MP;
              end
              OP_Y: begin
                nv <= srmc_pkg::sat_sub(ff, md_r);
                if (max_acc != '0) step <= OP_DA;
                else state <= ST_CLAMP;
              end
              OP_DA: begin
                // Both modes limit the change to one period of maximum acceleration.
                if (!vm_r) begin
                  if (nv < lo_c)      nv <= lo_c;
                  else if (nv > hi_c) nv <= hi_c;
                end else begin
                  if (dv > acc_a)       nv <= hi_c;
                  else if (dv < -acc_a) nv <= lo_c;
                end
                state <= ST_CLAMP;
              end
              OP_MP: begin
                mp   <= md_r;
                step <= OP_TERM;
              end
              OP_TERM: begin
                // Reverse the acceleration if that brings the error closer to zero.
                if (srmc_pkg::magnitude(srmc_pkg::sat_sub(err, md_r)) <
                    srmc_pkg::magnitude(err)) begin
                  ma   <= srmc_pkg::sat_neg(ma);
                  step <= OP_MP2;
                end else begin
                  nv    <= srmc_pkg::sat_add(cv, mp);
                  state <= ST_CLAMP;
                end
              end
              OP_MP2: begin
                nv    <= srmc_pkg::sat_add(cv, md_r);
                state <= ST_CLAMP;
              end
              OP_DV: begin
                dv   <= md_r;
                step <= OP_DA;
              end
              OP_RATE: begin
                res_pos <= acc;
                res_vel <= nv;
                res_dir <= dir;
                res_sp  <= !en_r ? 32'd0 : ((|rmag[63:32]) ? 32'hFFFF_FFFF : rmag[31:0]);
                state   <= ST_FIN;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_CLAMP: begin
          nv    <= nc;
          cv    <= nc;
          dir   <= !(nc != '0 && scale != '0 && (nc[63] != scale[31]));
          step  <= OP_RATE;
          state <= ST_ISSUE;
        end
        ST_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid             <= 1'b1;
            rsp.position_feedback <= res_pos;
            rsp.velocity_feedback <= res_vel;
            rsp.direction         <= res_dir;
            rsp.step_rate         <= res_sp;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/srmc_checker.sv =====
// Port-level checks of the step-rate controller, bound to its top level.
// Depends on step_rate_motion_controller_core_defines.svh.
`include "step_rate_motion_controller_core_defines.svh"

module srmc_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready
);

  // An accepted request keeps the block busy for at least the next cycle.
  `SRMC_ASSERT_NEXT(a_busy_after_request, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // Reset leaves the block ready with no result pending.
  `SRMC_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, cmd_ready && !rsp_valid)

  // A result that is not taken stays offered.
  `SRMC_ASSERT_NEXT(a_result_held, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // The input ready is never unknown once out of reset.
  `SRMC_ASSERT_NOW(a_ready_known, clk, rst, 1'b1, cmd_ready == 1'b0 || cmd_ready == 1'b1)

endmodule

bind step_rate_motion_controller_core srmc_checker u_srmc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);

// ===== tb/step_rate_motion_controller_core_tb.sv =====
// Self-checking testbench for step_rate_motion_controller_core.
// Depends on srmc_pkg and the srmc_cmd_if / srmc_rsp_if interfaces; a built-in
// predictor computes each servo result and a monitor compares it field by field.
`timescale 1ns / 1ps

module step_rate_motion_controller_core_tb;

  localparam logic [1:0] REG_POSITION_SCALE   = 2'd0;
  localparam logic [1:0] REG_MAX_VELOCITY     = 2'd1;
  localparam logic [1:0] REG_MAX_ACCELERATION = 2'd2;
  localparam logic [1:0] REG_SERVO_PERIOD     = 2'd3;

  localparam logic OP_LATCH  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam int DRAIN_CYCLES = 1200;
  localparam logic signed [63:0] BILLION = 64'sd1000000000;
  localparam logic signed [63:0] ONE_Q32 = 64'sh1_0000_0000;

  typedef struct {
    logic               op;
    logic signed [31:0] fb;
    logic signed [63:0] pc;
    logic signed [63:0] vc;
    logic               vmode;
    logic               en;
    logic               clr;
  } servo_req_t;

  typedef struct {
    logic signed [63:0] pos;
    logic signed [63:0] vel;
    logic               dir;
    logic [31:0]        rate;
  } servo_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_POSITION_SCALE;
  logic [62:0] cfg_data = '0;

  srmc_cmd_if cmd_ch();
  srmc_rsp_if rsp_ch();

  step_rate_motion_controller_core dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of configuration and servo state.
  logic signed [31:0] scale_q16 = 32'sd65536;
  logic [62:0]        vel_limit = '0;
  logic [62:0]        acc_limit = 63'h1_0000_0000;
  logic [26:0]        period_ns = 27'd1000000;
  logic signed [63:0] prev_pos_cmd = '0;
  logic [31:0]        prev_count = '0;
  logic signed [63:0] pos_acc = '0;
  logic signed [63:0] cur_vel = '0;

  servo_req_t pending_reqs[$];
  servo_rsp_t expected_rsps[$];
  int errors = 0;
  int n_accepted = 0, n_results = 0, n_latch = 0, n_cfg = 0;
  bit idle_bursts = 1'b1;
  bit hold_off = 1'b0;

  function automatic logic signed [63:0] plus_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return srmc_pkg::S64_MAX;
    if (a[63] && b[63] && !s[63]) return srmc_pkg::S64_MIN;
    return s;
  endfunction

  function automatic logic signed [63:0] minus_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (!a[63] && b[63] && s[63]) return srmc_pkg::S64_MAX;
    if (a[63] && !b[63] && !s[63]) return srmc_pkg::S64_MIN;
    return s;
  endfunction

  function automatic logic signed [63:0] negate_sat(logic signed [63:0] a);
    return (a == srmc_pkg::S64_MIN) ? srmc_pkg::S64_MAX : -a;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Exact x*m/d rounded half away from zero, saturated to signed 64 bits.
  function automatic logic signed [63:0] scaled_ratio(logic signed [63:0] x,
                                                      logic signed [63:0] m,
                                                      logic [63:0] d);
    logic [127:0] prod, quot, rem, den;
    logic [63:0] lim;
    logic neg;
    neg = x[63] != m[63];
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    prod = {64'd0, abs64(x)} * {64'd0, abs64(m)};
    den = {64'd0, d};
    if (prod == 0) return 64'sd0;
    if (d == 0) begin
      quot = {64'd0, lim};
    end else begin
      quot = prod / den;
      rem = prod % den;
      if (rem >= den - rem) quot = quot + 1;
      if (quot > {64'd0, lim}) quot = {64'd0, lim};
    end
    return neg ? -$signed(quot[63:0]) : $signed(quot[63:0]);
  endfunction

  function automatic logic signed [63:0] clamp_s64(logic signed [63:0] v,
                                                   logic signed [63:0] lo,
                                                   logic signed [63:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] tracking_velocity(logic signed [63:0] pc,
      logic signed [63:0] per, logic signed [63:0] tq, logic signed [63:0] acc);
    logic signed [63:0] ff, verr, ma, t, pam, pcam, err, v, da, mp, term;
    ff = scaled_ratio(minus_sat(pc, prev_pos_cmd), BILLION, per);
    prev_pos_cmd = pc;
    verr = minus_sat(cur_vel, ff);
    ma = 0;
    t = 0;
    if (verr != 0) begin
      if (acc == 0) begin
        ma = negate_sat(scaled_ratio(verr, BILLION, per));
        t = tq;
      end else begin
        ma = (verr > 0) ? -acc : acc;
        t = scaled_ratio(verr, ONE_Q32, acc);
        if (t < 0) t = negate_sat(t);
      end
    end
    pam = plus_sat(pos_acc, scaled_ratio(plus_sat(ff, cur_vel), plus_sat(t, tq),
                                         64'h2_0000_0000));
    pcam = plus_sat(pc, scaled_ratio(ff, t, ONE_Q32));
    err = minus_sat(pam, pcam);
    if (t < tq) begin
      v = minus_sat(ff, scaled_ratio(err, BILLION, 2 * per));
      if (acc > 0) begin
        da = scaled_ratio(acc, per, BILLION);
        v = clamp_s64(v, minus_sat(cur_vel, da), plus_sat(cur_vel, da));
      end
      return v;
    end
    mp = scaled_ratio(ma, tq, ONE_Q32);
    term = scaled_ratio(mp, t, 64'h4000_0000);
    if (abs64(minus_sat(err, term)) < abs64(err)) begin
      ma = negate_sat(ma);
      mp = scaled_ratio(ma, tq, ONE_Q32);
    end
    return plus_sat(cur_vel, mp);
  endfunction

  function automatic servo_rsp_t predict_servo(servo_req_t r);
    servo_rsp_t o;
    logic signed [63:0] s, per, acc, tq, phys, maxv, nv, dpos, dv, da, rate;
    logic [63:0] smag, sp;
    logic [31:0] delta;
    s = 64'(scale_q16);
    smag = abs64(s);
    per = (period_ns == 0) ? 64'sd1 : $signed({37'd0, period_ns});
    acc = $signed({1'b0, acc_limit});
    if (r.op == OP_LATCH) begin
      prev_count = r.fb;
      o.pos = pos_acc;
      o.vel = cur_vel;
      o.dir = 1'b0;
      o.rate = '0;
      return o;
    end
    delta = r.fb - prev_count;
    prev_count = r.fb;
    if (r.clr) begin
      pos_acc = 0;
    end else if (s != 0) begin
      dpos = scaled_ratio(64'($signed(delta)), ONE_Q32, smag);
      if (s < 0) dpos = negate_sat(dpos);
      pos_acc = plus_sat(pos_acc, dpos);
    end
    tq = scaled_ratio(per, ONE_Q32, BILLION);
    phys = scaled_ratio(64'(srmc_pkg::TICK_FREQUENCY), 64'sh8000_0000_0000, smag);
    maxv = (vel_limit == 0 || {1'b0, vel_limit} > phys) ? phys : $signed({1'b0, vel_limit});
    if (!r.vmode) begin
      nv = tracking_velocity(r.pc, per, tq, acc);
    end else begin
      nv = r.vc;
      if (acc > 0) begin
        dv = scaled_ratio(minus_sat(nv, cur_vel), BILLION, per);
        da = scaled_ratio(acc, per, BILLION);
        if (dv > acc) nv = plus_sat(cur_vel, da);
        else if (dv < -acc) nv = minus_sat(cur_vel, da);
      end
    end
    nv = clamp_s64(nv, -maxv, maxv);
    cur_vel = nv;
    o.pos = pos_acc;
    o.vel = nv;
    o.dir = !(nv != 0 && s != 0 && (nv[63] != s[63]));
    rate = scaled_ratio(nv, s, 64'(srmc_pkg::TICK_FREQUENCY)
                                 << (48 - srmc_pkg::RATE_FRACTION_BITS));
    sp = abs64(rate);
    if (sp > 64'hFFFF_FFFF) sp = 64'hFFFF_FFFF;
    if (!r.en) sp = 0;
    o.rate = sp[31:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Idling is switched off now and then for long stretches.
  always @(posedge clk) begin
    if ($urandom_range(0, 2999) == 0) idle_bursts <= !idle_bursts;
  end

  // Request driver.
  int send_gap = 0;
  bit offering = 1'b0;
  servo_req_t cur_req;
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_LATCH;
    cmd_ch.feedback_count = '0;
    cmd_ch.position_command = '0;
    cmd_ch.velocity_command = '0;
    cmd_ch.velocity_mode = 1'b0;
    cmd_ch.enable = 1'b0;
    cmd_ch.position_clear = 1'b0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      cmd_ch.valid <= 1'b0;
    end else begin
      if (offering && cmd_ch.ready) offering = 1'b0;
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          offering = 1'b1;
          cmd_ch.op <= cur_req.op;
          cmd_ch.feedback_count <= cur_req.fb;
          cmd_ch.position_command <= cur_req.pc;
          cmd_ch.velocity_command <= cur_req.vc;
          cmd_ch.velocity_mode <= cur_req.vmode;
          cmd_ch.enable <= cur_req.en;
          cmd_ch.position_clear <= cur_req.clr;
          if (idle_bursts && $urandom_range(0, 9) < 3) send_gap = pick_gap();
        end
      end
      cmd_ch.valid <= offering;
    end
  end

  // Prediction happens at the edge where a request is accepted.
  always @(posedge clk) begin
    servo_req_t r;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      r.op = cmd_ch.op;
      r.fb = cmd_ch.feedback_count;
      r.pc = cmd_ch.position_command;
      r.vc = cmd_ch.velocity_command;
      r.vmode = cmd_ch.velocity_mode;
      r.en = cmd_ch.enable;
      r.clr = cmd_ch.position_clear;
      expected_rsps.push_back(predict_servo(r));
      n_accepted++;
      if (r.op == OP_LATCH) n_latch++;
    end
  end

  // Long receiver hold-off once, so the block fills up and stalls its input.
  int hold_count = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && !hold_off && n_results == 400) begin
      hold_off <= 1'b1;
      hold_count = 3000;
    end else if (hold_off) begin
      if (hold_count > 0) begin
        hold_count--;
      end else begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_left > 0) stall_left--;
      else if (idle_bursts && $urandom_range(0, 9) < 3) stall_left = pick_gap();
      rsp_ch.ready <= !hold_off && stall_left == 0;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    servo_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no request outstanding at %0t", $realtime);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.position_feedback !== want.pos || rsp_ch.velocity_feedback !== want.vel ||
            rsp_ch.direction !== want.dir || rsp_ch.step_rate !== want.rate) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: pos %h/%h vel %h/%h dir %b/%b rate %h/%h (exp/act)",
                     n_results, want.pos, rsp_ch.position_feedback, want.vel,
                     rsp_ch.velocity_feedback, want.dir, rsp_ch.direction, want.rate,
                     rsp_ch.step_rate);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [62:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POSITION_SCALE: scale_q16 = val[31:0];
      REG_MAX_VELOCITY: vel_limit = val;
      REG_MAX_ACCELERATION: acc_limit = val;
      default: period_ns = val[26:0];
    endcase
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || offering || expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_req(logic op, logic signed [31:0] fb, logic signed [63:0] pc,
                         logic signed [63:0] vc, logic vm, logic en, logic clr);
    servo_req_t r;
    r.op = op; r.fb = fb; r.pc = pc; r.vc = vc;
    r.vmode = vm; r.en = en; r.clr = clr;
    pending_reqs.push_back(r);
  endtask

  function automatic logic signed [63:0] rand64();
    return $signed({$urandom, $urandom});
  endfunction

  // Mostly coherent trajectories with random content, some wild values mixed in.
  logic signed [63:0] traj_pos = '0;
  logic signed [31:0] traj_count = '0;
  task automatic add_random(int n);
    logic signed [63:0] step, pc, vc;
    logic signed [31:0] fb;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      step = $signed({28'd0, 4'($urandom_range(0, 8)), $urandom});
      if ($urandom_range(0, 1)) step = -step;
      traj_pos = traj_pos + step;
      traj_count = traj_count + 32'($signed($urandom_range(0, 400000)) - 200000);
      pc = (p < 90) ? traj_pos : rand64();
      fb = (p < 85) ? traj_count : $signed($urandom);
      vc = (p < 80) ? step * 1000 : rand64();
      add_req(($urandom_range(0, 9) < 2) ? OP_LATCH : OP_UPDATE, fb, pc, vc,
              $urandom_range(0, 2) == 0, $urandom_range(0, 9) != 0,
              $urandom_range(0, 29) == 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: latch, zero update, extreme commands, counter wrap, disable, clear.
    add_req(OP_LATCH, 32'sd0, 0, 0, 1'b0, 1'b1, 1'b0);
    add_req(OP_UPDATE, 32'sd0, 0, 0, 1'b0, 1'b1, 1'b0);
    add_req(OP_UPDATE, 32'sd65536, 64'sh1_0000_0000, 0, 1'b0, 1'b1, 1'b0);
    add_req(OP_UPDATE, 32'sh7FFF_FFFF, srmc_pkg::S64_MAX, 0, 1'b0, 1'b1, 1'b0);
    add_req(OP_UPDATE, 32'sh8000_0000, srmc_pkg::S64_MIN, 0, 1'b0, 1'b1, 1'b0);
    add_req(OP_LATCH, 32'sh7FFF_FFFF, 0, 0, 1'b0, 1'b0, 1'b0);
    add_req(OP_UPDATE, 32'sh8000_0000, srmc_pkg::S64_MIN, srmc_pkg::S64_MAX, 1'b1, 1'b1,
            1'b0);
    add_req(OP_UPDATE, -32'sd1, 0, srmc_pkg::S64_MIN, 1'b1, 1'b1, 1'b0);
    add_req(OP_UPDATE, 32'sd0, 0, 64'sh5_0000_0000, 1'b1, 1'b0, 1'b0);
    add_req(OP_UPDATE, 32'sd1000, 64'sh7_0000_0000, 0, 1'b0, 1'b1, 1'b1);
    add_req(OP_UPDATE, 32'sd2000, -64'sh7_0000_0000, 0, 1'b0, 1'b1, 1'b0);
    add_req(OP_LATCH, -32'sd5000, 0, 0, 1'b1, 1'b1, 1'b1);
    add_req(OP_UPDATE, 32'sd5000, 0, -64'sh1_0000_0000, 1'b1, 1'b1, 1'b0);
    wait_idle();

    // Physical limit with large scale, no acceleration limiting, longest period.
    write_reg(REG_POSITION_SCALE, 63'h7FFF_FFFF);
    write_reg(REG_MAX_ACCELERATION, '0);
    write_reg(REG_SERVO_PERIOD, 27'd100000000);
    add_req(OP_UPDATE, 32'sd123, srmc_pkg::S64_MAX, srmc_pkg::S64_MAX, 1'b0, 1'b1, 1'b0);
    add_req(OP_UPDATE, 32'sd0, srmc_pkg::S64_MIN, srmc_pkg::S64_MIN, 1'b1, 1'b1, 1'b0);
    add_random(230);
    wait_idle();

    // Most negative scale, huge acceleration, shortest period, small velocity limit.
    write_reg(REG_POSITION_SCALE, 63'h8000_0000);
    write_reg(REG_MAX_ACCELERATION, {63{1'b1}});
    write_reg(REG_SERVO_PERIOD, 27'd1000);
    write_reg(REG_MAX_VELOCITY, 63'h3_0000_0000);
    add_random(250);
    wait_idle();

    // Zero scale: no position change, zero rate, forward direction.
    write_reg(REG_POSITION_SCALE, '0);
    write_reg(REG_MAX_VELOCITY, {63{1'b1}});
    write_reg(REG_MAX_ACCELERATION, 63'h10_0000_0000);
    write_reg(REG_SERVO_PERIOD, 27'd250000);
    add_random(240);
    wait_idle();

    // Moderate fractional negative scale and a velocity limit above the physical one.
    write_reg(REG_POSITION_SCALE, 63'hFFFF_0C00);
    write_reg(REG_MAX_VELOCITY, 63'h7FFF_0000_0000_0000);
    write_reg(REG_MAX_ACCELERATION, 63'h1);
    write_reg(REG_SERVO_PERIOD, 27'd1000000);
    add_random(250);
    wait_idle();

    write_reg(REG_POSITION_SCALE, 63'h64_0000);
    write_reg(REG_MAX_VELOCITY, '0);
    write_reg(REG_MAX_ACCELERATION, 63'h2_0000_0000);
    write_reg(REG_SERVO_PERIOD, 27'd500000);
    add_random(270);
    wait_idle();

    errors += expected_rsps.size();
    $display("Covered %0d requests (%0d latch) and %0d results over %0d register writes.",
             n_accepted, n_latch, n_results, n_cfg);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
